// ===== design/ls3_pkg.sv =====
// Shared widths and payload types of the 3x3 Cramer's rule solver.
package ls3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Cross product components, dot product terms and determinants.
    localparam int XW   = 2 * DATA_WIDTH + 1;
    localparam int PPW  = 2 * DATA_WIDTH + 1;
    localparam int TW   = 3 * DATA_WIDTH + 1;
    localparam int DETW = 3 * DATA_WIDTH + 3;

    // Divider: quotient bits, remainder width and scaled numerator width.
    localparam int QW = DATA_WIDTH + 2;
    localparam int RW = DETW + 1;
    localparam int NW = DETW + FRAC_BITS + 1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] m11;
        logic signed [DATA_WIDTH-1:0] m12;
        logic signed [DATA_WIDTH-1:0] m13;
        logic signed [DATA_WIDTH-1:0] m21;
        logic signed [DATA_WIDTH-1:0] m22;
        logic signed [DATA_WIDTH-1:0] m23;
        logic signed [DATA_WIDTH-1:0] m31;
        logic signed [DATA_WIDTH-1:0] m32;
        logic signed [DATA_WIDTH-1:0] m33;
        logic signed [DATA_WIDTH-1:0] r1;
        logic signed [DATA_WIDTH-1:0] r2;
        logic signed [DATA_WIDTH-1:0] r3;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sol1;
        logic signed [DATA_WIDTH-1:0] sol2;
        logic signed [DATA_WIDTH-1:0] sol3;
        logic                         solved;
    } out_item_t;

    typedef struct packed {
        logic [DETW-1:0] dm;
        logic [DETW-1:0] d1;
        logic [DETW-1:0] d2;
        logic [DETW-1:0] d3;
    } det_set_t;

endpackage

// ===== design/ls3_front.sv =====
// Determinant pipeline: det(M) and the three Cramer determinants, exact.
module ls3_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ls3_pkg::in_item_t    s_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ls3_pkg::det_set_t    out_data
);
    localparam int DW   = ls3_pkg::DATA_WIDTH;
    localparam int XW   = ls3_pkg::XW;
    localparam int PPW  = ls3_pkg::PPW;
    localparam int TW   = ls3_pkg::TW;
    localparam int DETW = ls3_pkg::DETW;

    logic signed [DW-1:0]   col [4][3];
    logic [4:0]             vld_reg;
    logic                   en;

    logic signed [2*DW-1:0] pp_reg [3][3], pp_next [3][3];
    logic signed [2*DW-1:0] pn_reg [3][3], pn_next [3][3];
    logic signed [DW-1:0]   a1_reg [3], r1_reg [3];
    logic signed [XW-1:0]   x_reg [3][3], x_next [3][3];
    logic signed [DW-1:0]   a2_reg [3], r2_reg [3];
    logic signed [PPW-1:0]  pl_reg [4][3], pl_next [4][3];
    logic signed [PPW-1:0]  ph_reg [4][3], ph_next [4][3];
    logic signed [TW-1:0]   t_reg [4][3], t_next [4][3];
    logic signed [DETW-1:0] det_reg [4], det_next [4];

    assign en        = !vld_reg[4] || out_ready;
    assign s_ready   = en;
    assign out_valid = vld_reg[4];
    assign out_data  = '{dm: det_reg[0], d1: det_reg[1], d2: det_reg[2], d3: det_reg[3]};

    // Columns a, b, c of the matrix and the right-hand side r.
    always_comb begin
        col[0] = '{s_data.m11, s_data.m21, s_data.m31};
        col[1] = '{s_data.m12, s_data.m22, s_data.m32};
        col[2] = '{s_data.m13, s_data.m23, s_data.m33};
        col[3] = '{s_data.r1,  s_data.r2,  s_data.r3};
    end

    // Cross products b x c, r x c and b x r; each determinant is then a dot
    // product with one of them.
    always_comb begin
        int ui, vi, j, k;
        for (int x = 0; x < 3; x++) begin
            ui = (x == 1) ? 3 : 1;
            vi = (x == 2) ? 3 : 2;
            for (int i = 0; i < 3; i++) begin
                j = (i == 2) ? 0 : i + 1;
                k = (i == 0) ? 2 : i - 1;
                pp_next[x][i] = col[ui][j] * col[vi][k];
                pn_next[x][i] = col[ui][k] * col[vi][j];
                x_next[x][i]  = XW'(pp_reg[x][i]) - XW'(pn_reg[x][i]);
            end
        end
    end

    // Each term splits the cross component into a low unsigned half and a
    // high signed half so that no multiplier exceeds about 33 by 33 bits.
    always_comb begin
        logic signed [DW-1:0] v;
        logic signed [XW-1:0] xc;
        for (int d = 0; d < 4; d++) begin
            for (int i = 0; i < 3; i++) begin
                v  = (d == 1) ? r2_reg[i] : a2_reg[i];
                xc = (d <= 1) ? x_reg[0][i] : ((d == 2) ? x_reg[1][i] : x_reg[2][i]);
                pl_next[d][i] = v * $signed({1'b0, xc[DW-1:0]});
                ph_next[d][i] = v * $signed(xc[XW-1:DW]);
                t_next[d][i]  = (TW'(ph_reg[d][i]) <<< DW) + TW'(pl_reg[d][i]);
            end
            det_next[d] = DETW'(t_reg[d][0]) + DETW'(t_reg[d][1]) + DETW'(t_reg[d][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], s_valid};
        end
        if (en) begin
            pp_reg  <= pp_next;
            pn_reg  <= pn_next;
            a1_reg  <= col[0];
            r1_reg  <= col[3];
            x_reg   <= x_next;
            a2_reg  <= a1_reg;
            r2_reg  <= r1_reg;
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            t_reg   <= t_next;
            det_reg <= det_next;
        end
    end

endmodule

// ===== design/ls3_queue.sv =====
// Two-entry queue of determinant sets between the front and back pipelines.
module ls3_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  ls3_pkg::det_set_t    push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output ls3_pkg::det_set_t    pop_data
);
    ls3_pkg::det_set_t entry_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/ls3_back.sv =====
// Division pipeline: one quotient bit per stage, rounding and range check.
module ls3_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ls3_pkg::det_set_t    in_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ls3_pkg::out_item_t   m_data
);
    localparam int DW   = ls3_pkg::DATA_WIDTH;
    localparam int FB   = ls3_pkg::FRAC_BITS;
    localparam int DETW = ls3_pkg::DETW;
    localparam int QW   = ls3_pkg::QW;
    localparam int RW   = ls3_pkg::RW;
    localparam int NW   = ls3_pkg::NW;
    localparam logic [QW-1:0] LIM = {{(QW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}};

    logic                 en;
    logic [QW:0]          vld_reg;
    logic [RW-1:0]        rem_reg [QW+1][3], rem_next [QW+1][3];
    logic [QW-1:0]        lo_reg  [QW+1][3], lo_next  [QW+1][3];
    logic [QW-1:0]        quo_reg [QW+1][3], quo_next [QW+1][3];
    logic [DETW-1:0]      den_reg [QW+1],    den_next [QW+1];
    logic [2:0]           neg_reg [QW+1],    neg_next [QW+1];
    logic                 ok_reg  [QW+1],    ok_next  [QW+1];
    logic                 m_valid_reg;
    ls3_pkg::out_item_t   m_data_reg, m_data_next;

    assign en       = !m_valid_reg || m_ready;
    assign in_ready = en;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Entry stage: magnitudes, signs, and an early overflow test. The
    // numerator is doubled so that the divider yields one extra bit for
    // rounding; a quotient of QW bits or more is out of range anyway.
    always_comb begin
        logic signed [DETW-1:0] ds [4];
        logic [DETW-1:0]        mag;
        logic [NW-1:0]          num;
        logic                   over;
        ds[0] = $signed(in_data.dm);
        ds[1] = $signed(in_data.d1);
        ds[2] = $signed(in_data.d2);
        ds[3] = $signed(in_data.d3);
        den_next[0] = ds[0][DETW-1] ? DETW'(-ds[0]) : ds[0];
        over = 1'b0;
        for (int k = 0; k < 3; k++) begin
            mag = ds[k+1][DETW-1] ? DETW'(-ds[k+1]) : ds[k+1];
            num = {mag, {(FB+1){1'b0}}};
            over = over || (num[NW-1:QW] >= den_next[0]);
            rem_next[0][k] = RW'(num[NW-1:QW]);
            lo_next[0][k]  = num[QW-1:0];
            quo_next[0][k] = '0;
            neg_next[0][k] = ds[k+1][DETW-1] ^ ds[0][DETW-1];
        end
        ok_next[0] = (den_next[0] != '0) && !over;

        for (int s = 1; s <= QW; s++) begin
            logic [RW-1:0] sh;
            logic          ge;
            den_next[s] = den_reg[s-1];
            neg_next[s] = neg_reg[s-1];
            ok_next[s]  = ok_reg[s-1];
            for (int k = 0; k < 3; k++) begin
                sh = {rem_reg[s-1][k][RW-2:0], lo_reg[s-1][k][QW-1]};
                ge = (sh >= {1'b0, den_reg[s-1]});
                rem_next[s][k] = ge ? sh - {1'b0, den_reg[s-1]} : sh;
                lo_next[s][k]  = lo_reg[s-1][k] << 1;
                quo_next[s][k] = {quo_reg[s-1][k][QW-2:0], ge};
            end
        end
    end

    // Round half away from zero on the magnitude, then check the range.
    always_comb begin
        logic [QW:0]          qs;
        logic [QW-1:0]        qr;
        logic                 ok;
        logic signed [DW-1:0] sol [3];
        ok = ok_reg[QW];
        for (int k = 0; k < 3; k++) begin
            qs = (QW+1)'(quo_reg[QW][k]) + 1'b1;
            qr = qs[QW:1];
            if (qr > LIM || (qr == LIM && !neg_reg[QW][k])) begin
                ok = 1'b0;
            end
            sol[k] = neg_reg[QW][k] ? -qr[DW-1:0] : qr[DW-1:0];
        end
        m_data_next.sol1   = ok ? sol[0] : '0;
        m_data_next.sol2   = ok ? sol[1] : '0;
        m_data_next.sol3   = ok ? sol[2] : '0;
        m_data_next.solved = ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[QW-1:0], in_valid};
            m_valid_reg <= vld_reg[QW];
        end
        if (en) begin
            rem_reg    <= rem_next;
            lo_reg     <= lo_next;
            quo_reg    <= quo_next;
            den_reg    <= den_next;
            neg_reg    <= neg_next;
            ok_reg     <= ok_next;
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ===== design/linear_solve_3x3_cramer.sv =====
// A result passes 5 determinant stages, 1 queue stage, 1 entry stage, 34 divider
// stages and the output register. The divider gives one quotient bit per stage.
// Throughput: one system per cycle while the result side does not stall.
// A stall on the result side fills the two-entry queue before the input stalls.
// Reset (aresetn, synchronous, active low) empties every pipeline and the queue.
// Top level of the 3x3 Cramer's rule solver.
module linear_solve_3x3_cramer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ls3_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ls3_pkg::out_item_t   m_data
);
    logic              f_valid, f_ready, b_valid, b_ready;
    ls3_pkg::det_set_t f_data, b_data;

    ls3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    ls3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    ls3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_data  (b_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== design/ls3_checker.sv =====
// Port-level checks of the solver, bound to its top level.
module ls3_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ls3_pkg::out_item_t  m_data
);
    // A stalled result must hold until its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A failed solve must report all-zero solutions.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.solved |->
            m_data.sol1 == '0 && m_data.sol2 == '0 && m_data.sol3 == '0)
        else $error("failed solve with nonzero solution");

    // Reset empties the pipelines: no result and room for input.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind linear_solve_3x3_cramer ls3_checker u_ls3_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the 3x3 Cramer's rule linear solver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 41;

    typedef logic signed [191:0] wide_t;
    typedef logic signed [ls3_pkg::DATA_WIDTH-1:0] field_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    ls3_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    ls3_pkg::out_item_t m_data;

    ls3_pkg::out_item_t solutions_due[$];
    int                 failures;
    int                 sent_items;
    int                 checked_items;
    int                 solved_count;
    bit                 calm_period;

    linear_solve_3x3_cramer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    function automatic wide_t ext(field_t v);
        return wide_t'(v);
    endfunction

    function automatic wide_t det3(wide_t a, wide_t b, wide_t c, wide_t d, wide_t e,
                                   wide_t f, wide_t g, wide_t h, wide_t i);
        return a*e*i + b*f*g + c*d*h - c*e*g - b*d*i - a*f*h;
    endfunction

    // Exact Cramer solve; the quotient is rounded half away from zero.
    function automatic ls3_pkg::out_item_t solve_system(ls3_pkg::in_item_t x);
        ls3_pkg::out_item_t res;
        wide_t              dm, dk, num, den, q;
        wide_t              lim;
        bit                 ok;
        bit                 neg;
        field_t             sol [3];
        lim = wide_t'(1) <<< (ls3_pkg::DATA_WIDTH - 1);
        dm  = det3(ext(x.m11), ext(x.m12), ext(x.m13), ext(x.m21), ext(x.m22),
                   ext(x.m23), ext(x.m31), ext(x.m32), ext(x.m33));
        ok  = (dm != 0);
        den = (dm < 0) ? -dm : dm;
        for (int k = 0; k < 3; k++) begin
            sol[k] = '0;
            if (ok) begin
                case (k)
                    0: dk = det3(ext(x.r1), ext(x.m12), ext(x.m13), ext(x.r2), ext(x.m22),
                                 ext(x.m23), ext(x.r3), ext(x.m32), ext(x.m33));
                    1: dk = det3(ext(x.m11), ext(x.r1), ext(x.m13), ext(x.m21), ext(x.r2),
                                 ext(x.m23), ext(x.m31), ext(x.r3), ext(x.m33));
                    default: dk = det3(ext(x.m11), ext(x.m12), ext(x.r1), ext(x.m21),
                                       ext(x.m22), ext(x.r2), ext(x.m31), ext(x.m32),
                                       ext(x.r3));
                endcase
                neg = (dk < 0) != (dm < 0);
                num = ((dk < 0) ? -dk : dk) <<< ls3_pkg::FRAC_BITS;
                q   = (2 * num + den) / (2 * den);
                if (q > lim || (q == lim && !neg))
                    ok = 1'b0;
                else
                    sol[k] = ls3_pkg::DATA_WIDTH'(neg ? -q : q);
            end
        end
        res.sol1   = ok ? sol[0] : '0;
        res.sol2   = ok ? sol[1] : '0;
        res.sol3   = ok ? sol[2] : '0;
        res.solved = ok;
        return res;
    endfunction

    function automatic bit idle_now();
        return !calm_period && ($urandom_range(0, 99) < 35);
    endfunction

    task automatic send_system(ls3_pkg::in_item_t x);
        while (idle_now()) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
        solutions_due.push_back(solve_system(x));
        sent_items++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (solutions_due.size() != 0) @(negedge aclk);
    endtask

    function automatic field_t full_rand();
        return $urandom;
    endfunction

    // Values within +-8.0, so that most systems give solutions in range.
    function automatic field_t modest_rand();
        return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    function automatic ls3_pkg::in_item_t diag_system(field_t d, field_t r);
        ls3_pkg::in_item_t x;
        x = '0;
        x.m11 = d; x.m22 = d; x.m33 = d;
        x.r1 = r; x.r2 = -r; x.r3 = r;
        return x;
    endfunction

    task automatic test_directed();
        ls3_pkg::in_item_t x;
        localparam field_t ONE  = 1 <<< ls3_pkg::FRAC_BITS;
        localparam field_t MAXV = {1'b0, {(ls3_pkg::DATA_WIDTH-1){1'b1}}};
        localparam field_t MINV = {1'b1, {(ls3_pkg::DATA_WIDTH-1){1'b0}}};
        send_system(diag_system(ONE, 3 * ONE));
        send_system(diag_system(ONE, MAXV));
        send_system(diag_system(ONE, MINV));
        send_system(diag_system(-ONE, MINV));           // overflow on negation
        send_system(diag_system('0, ONE));              // zero matrix is singular
        send_system(diag_system(MAXV, MAXV));
        send_system(diag_system(MINV, MINV));
        send_system(diag_system(MINV, MAXV));
        send_system(diag_system(2 * ONE, 1));           // exact half rounds up
        send_system(diag_system(2 * ONE, -1));          // and down when negative
        send_system(diag_system(2 * ONE, 3));
        send_system(diag_system(1, 1));                 // tiny determinant, solutions of +-1.0
        send_system(diag_system(ONE >>> 1, MAXV >>> 1));
        x = '1;
        send_system(x);
        x = {12{MAXV}};
        send_system(x);
        x = {12{MINV}};
        send_system(x);
        // Two equal rows make the matrix singular.
        x = '0;
        x.m11 = ONE; x.m12 = 2 * ONE; x.m13 = 3 * ONE;
        x.m21 = ONE; x.m22 = 2 * ONE; x.m23 = 3 * ONE;
        x.m31 = 5;   x.m33 = -7;
        x.r1 = ONE;
        send_system(x);
        x.m21 = 4 * ONE; x.m22 = 5 * ONE; x.m23 = 6 * ONE;
        x.m32 = MINV; x.r2 = MAXV; x.r3 = MINV;
        send_system(x);
    endtask

    task automatic test_random_modest(int n);
        ls3_pkg::in_item_t x;
        for (int k = 0; k < n; k++) begin
            x.m11 = modest_rand(); x.m12 = modest_rand(); x.m13 = modest_rand();
            x.m21 = modest_rand(); x.m22 = modest_rand(); x.m23 = modest_rand();
            x.m31 = modest_rand(); x.m32 = modest_rand(); x.m33 = modest_rand();
            x.r1  = modest_rand(); x.r2  = modest_rand(); x.r3  = modest_rand();
            // Now and then copy a row so the singular path is exercised.
            if ($urandom_range(0, 9) == 0) begin
                x.m31 = x.m11; x.m32 = x.m12; x.m33 = x.m13;
            end
            send_system(x);
        end
    endtask

    task automatic test_random_full(int n);
        ls3_pkg::in_item_t x;
        for (int k = 0; k < n; k++) begin
            x.m11 = full_rand(); x.m12 = full_rand(); x.m13 = full_rand();
            x.m21 = full_rand(); x.m22 = full_rand(); x.m23 = full_rand();
            x.m31 = full_rand(); x.m32 = full_rand(); x.m33 = full_rand();
            x.r1  = full_rand(); x.r2  = full_rand(); x.r3  = full_rand();
            send_system(x);
        end
    endtask

    // Small determinant against a large right-hand side, close to the range limit.
    task automatic test_near_overflow(int n);
        ls3_pkg::in_item_t x;
        for (int k = 0; k < n; k++) begin
            x = '0;
            x.m11 = $signed($urandom_range(1, 1 << 17)) * ($urandom_range(0, 1) ? 1 : -1);
            x.m22 = 1 << ls3_pkg::FRAC_BITS;
            x.m33 = 1 << ls3_pkg::FRAC_BITS;
            x.m12 = modest_rand() >>> 8;
            x.r1  = full_rand();
            x.r2  = full_rand() >>> $urandom_range(0, 20);
            x.r3  = full_rand() >>> $urandom_range(0, 20);
            send_system(x);
        end
    endtask

    task automatic test_back_to_back(int n);
        calm_period = 1'b1;
        test_random_modest(n);
        calm_period = 1'b0;
    endtask

    task automatic test_pause_until_empty();
        test_random_modest(10);
        drain_results();
        test_random_full(10);
    endtask

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !idle_now();
    end

    always @(posedge aclk) begin
        ls3_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (solutions_due.size() == 0) begin
                $error("result transfer with no solution pending");
                failures++;
            end else begin
                want = solutions_due.pop_front();
                checked_items++;
                if (want.solved)
                    solved_count++;
                if (m_data.sol1 !== want.sol1) begin
                    $error("sol1: expected %0d, got %0d", want.sol1, m_data.sol1);
                    failures++;
                end
                if (m_data.sol2 !== want.sol2) begin
                    $error("sol2: expected %0d, got %0d", want.sol2, m_data.sol2);
                    failures++;
                end
                if (m_data.sol3 !== want.sol3) begin
                    $error("sol3: expected %0d, got %0d", want.sol3, m_data.sol3);
                    failures++;
                end
                if (m_data.solved !== want.solved) begin
                    $error("solved: expected %0d, got %0d", want.solved, m_data.solved);
                    failures++;
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        failures      = 0;
        sent_items    = 0;
        checked_items = 0;
        solved_count  = 0;
        calm_period   = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_modest(500);
        test_back_to_back(150);
        test_pause_until_empty();
        test_random_full(200);
        test_near_overflow(200);

        drain_results();
        repeat (LATENCY + 10) @(negedge aclk);
        if (solutions_due.size() != 0) begin
            $error("%0d solutions never arrived", solutions_due.size());
            failures++;
        end
        $display("Sent %0d systems, checked %0d results, %0d of them solved.",
                 sent_items, checked_items, solved_count);
        $display("Covered singular, overflowing, rounding and full-range systems.");
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
design/ls3_pkg.sv
design/ls3_front.sv
design/ls3_queue.sv
design/ls3_back.sv
design/linear_solve_3x3_cramer.sv
design/ls3_checker.sv
dv/tb_top.sv
